[design/scfe_pkg.sv]
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types, byte codes and the CRC-16 update for the SLIP frame encoder.
// ----------------------------------------------------------------------------
package scfe_pkg;

	localparam logic [7:0]  FEND     = 8'hC0;
	localparam logic [7:0]  FESC     = 8'hDB;
	localparam logic [7:0]  TFEND    = 8'hDC;
	localparam logic [7:0]  TFESC    = 8'hDD;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_start;
		logic        frame_end;
		logic [15:0] crc;
	} scfe_entry_t;

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_DATA,
		PH_HI,
		PH_LO,
		PH_CLOSE
	} scfe_phase_t;

	typedef enum logic [1:0] {
		FOLD_IDLE,
		FOLD_HI,
		FOLD_LO
	} scfe_fold_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[design/scfe_front.sv]
// ----------------------------------------------------------------------------
// scfe_front
// Accepts frame bytes, runs the CRC and pushes one classified entry per beat.
// ----------------------------------------------------------------------------
module scfe_front import scfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic        frame_end,
	input  logic        q_full,
	output logic        q_push,
	output scfe_entry_t q_entry
);

	logic [15:0] crc_q;
	logic [7:0]  lo_q;
	scfe_fold_t  fold_q;
	scfe_fold_t  nxt_fold;
	logic [15:0] crc_base;
	logic [15:0] crc_new;

	assign in_stall = q_full || (fold_q != FOLD_IDLE);
	assign q_push   = in_valid && !in_stall;
	assign crc_base = frame_start ? CRC_SEED : crc_q;
	assign crc_new  = crc_update(crc_base, data_byte);

	always_comb begin
		q_entry.data_byte   = data_byte;
		q_entry.frame_start = frame_start;
		q_entry.frame_end   = frame_end;
		q_entry.crc         = crc_new;
	end

	always_comb begin
		nxt_fold = fold_q;
		unique case (fold_q)
			FOLD_IDLE: begin
				if (q_push && frame_end) begin
					nxt_fold = FOLD_HI;
				end
			end
			FOLD_HI: nxt_fold = FOLD_LO;
			default: nxt_fold = FOLD_IDLE;
		endcase
	end

	// fold the trailer bytes into the running CRC after a frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_SEED;
			fold_q <= FOLD_IDLE;
		end else begin
			fold_q <= nxt_fold;
			unique case (fold_q)
				FOLD_HI: crc_q <= crc_update(crc_q, crc_q[15:8]);
				FOLD_LO: crc_q <= crc_update(crc_q, lo_q);
				default: begin
					if (q_push) begin
						crc_q <= crc_new;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fold_q == FOLD_HI) begin
			lo_q <= crc_q[7:0];
		end
	end

endmodule

[design/scfe_queue.sv]
// ----------------------------------------------------------------------------
// scfe_queue
// Short entry queue between the front and the back.
// ----------------------------------------------------------------------------
module scfe_queue import scfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  scfe_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output scfe_entry_t head,
	output logic        empty
);

	scfe_entry_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_q;
	logic [QUEUE_AW-1:0]   rd_q;
	logic [QUEUE_AW:0]     cnt_q;

	assign full  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/scfe_back.sv]
// ----------------------------------------------------------------------------
// scfe_back
// Walks each entry: open END on frame start, data, CRC and close on frame end,
// with escaping, one line byte per beat into the output register.
// ----------------------------------------------------------------------------
module scfe_back import scfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  scfe_entry_t head,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        closes_frame,
	output logic        run_last
);

	scfe_phase_t phase_q;
	scfe_phase_t cur_phase;
	scfe_phase_t nxt_phase;
	logic        active_q;
	logic        esc_q;
	logic        nxt_active;
	logic        nxt_esc;
	logic        out_valid_q;
	logic        load;
	logic        fire;
	logic [7:0]  src;
	logic        special;
	logic        step_done;
	logic        item_last;
	logic [7:0]  byte_val;
	logic        closes_val;

	assign load      = !out_valid_q || !out_stall;
	assign fire      = !q_empty && load;
	assign q_pop     = fire && item_last;
	assign out_valid = out_valid_q;

	// byte and flags for the current step
	always_comb begin
		cur_phase = active_q ? phase_q : (head.frame_start ? PH_OPEN : PH_DATA);
		unique case (cur_phase)
			PH_DATA: src = head.data_byte;
			PH_HI:   src = head.crc[15:8];
			PH_LO:   src = head.crc[7:0];
			default: src = FEND;
		endcase
		special    = (src == FEND) || (src == FESC);
		closes_val = (cur_phase == PH_CLOSE);
		if (cur_phase == PH_OPEN || cur_phase == PH_CLOSE) begin
			byte_val  = FEND;
			step_done = 1'b1;
		end else if (esc_q) begin
			byte_val  = (src == FEND) ? TFEND : TFESC;
			step_done = 1'b1;
		end else if (special) begin
			byte_val  = FESC;
			step_done = 1'b0;
		end else begin
			byte_val  = src;
			step_done = 1'b1;
		end
		item_last = step_done &&
			((cur_phase == PH_DATA && !head.frame_end) || cur_phase == PH_CLOSE);
	end

	// next phase
	always_comb begin
		nxt_phase  = phase_q;
		nxt_esc    = esc_q;
		nxt_active = active_q;
		if (fire) begin
			if (!step_done) begin
				nxt_phase  = cur_phase;
				nxt_esc    = 1'b1;
				nxt_active = 1'b1;
			end else begin
				nxt_esc    = 1'b0;
				nxt_active = !item_last;
				unique case (cur_phase)
					PH_OPEN:  nxt_phase = PH_DATA;
					PH_DATA:  nxt_phase = PH_HI;
					PH_HI:    nxt_phase = PH_LO;
					PH_LO:    nxt_phase = PH_CLOSE;
					default:  nxt_phase = PH_OPEN;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			active_q    <= 1'b0;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= nxt_phase;
			active_q <= nxt_active;
			esc_q    <= nxt_esc;
			if (load) begin
				out_valid_q <= !q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte     <= byte_val;
			closes_frame <= closes_val;
			run_last     <= item_last;
		end
	end

endmodule

[design/slip_crc16_frame_encoder_top.sv]
// ----------------------------------------------------------------------------
// slip_crc16_frame_encoder_top
// SLIP frame encoder with CRC-16 trailer: frame bytes in, line bytes out.
//
//   channel  handshake            payload
//   input    in_valid/in_stall    data_byte, frame_start, frame_end
//   output   out_valid/out_stall  out_byte, closes_frame, run_last
//
// One line byte leaves per cycle while entries wait and out_stall is low;
// a plain data byte gives one line byte, an escaped byte two, a frame start
// adds its opening END, and a frame end adds two to four trailer bytes and
// the closing END. The front takes one byte per cycle while the four-entry
// queue has room, and stalls after a frame end while the trailer is folded
// into the CRC. Reset seeds the CRC to all ones and empties queue and output.
// Output stall holds the output register and backs up through the queue.
// ----------------------------------------------------------------------------
module slip_crc16_frame_encoder_top import scfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       closes_frame,
	output logic       run_last
);

	scfe_entry_t push_entry;
	scfe_entry_t head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	scfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (push_entry)
	);

	scfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head),
		.empty      (q_empty)
	);

	scfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.closes_frame (closes_frame),
		.run_last     (run_last)
	);

endmodule
